@@ sv/hkbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hkbd_pkg
// Shared types, constants and the key code to ASCII map for the HID boot
// keyboard report decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hkbd_pkg;

    localparam int unsigned REPORT_SLOTS = 6;
    localparam int unsigned CODE_W       = 8;
    localparam int unsigned CHAR_W       = 7;
    localparam int unsigned IN_DATA_W    = CODE_W * (REPORT_SLOTS + 1);
    localparam int unsigned OUT_DATA_W   = 8;

    localparam logic [CODE_W-1:0] CODE_LIMIT = 8'd128;
    localparam logic [CODE_W-1:0] SHIFT_MASK = 8'h22;
    localparam logic [CHAR_W-1:0] ASCII_LF   = 7'h0A;
    localparam logic [CHAR_W-1:0] ASCII_ESC  = 7'h1B;
    localparam logic [CHAR_W-1:0] ASCII_BS   = 7'h08;
    localparam logic [CHAR_W-1:0] ASCII_TAB  = 7'h09;
    localparam logic [CHAR_W-1:0] ASCII_DEL  = 7'h7F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QUAL,
        ST_CHECK,
        ST_FINISH
    } t_state;

    // result of the shared compare unit
    typedef struct packed {
        logic code_ok;
        logic match;
    } t_cmp_res;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic found;
        logic commit;
        logic store;
    } t_cmd;

    function automatic logic [CHAR_W-1:0] f_keymap(input logic [CHAR_W-1:0] code,
                                                   input logic              shift);
        logic [CHAR_W-1:0] v;
        v = '0;
        if (code inside {[7'h04:7'h1D]}) begin
            v = shift ? CHAR_W'(code + 7'h3D) : CHAR_W'(code + 7'h5D);
        end else if (!shift && (code inside {[7'h1E:7'h26]})) begin
            v = CHAR_W'(code + 7'h13);
        end else begin
            case (code)
                7'h1E:   v = 7'h21;
                7'h1F:   v = 7'h40;
                7'h20:   v = 7'h23;
                7'h21:   v = 7'h24;
                7'h22:   v = 7'h25;
                7'h23:   v = 7'h5E;
                7'h24:   v = 7'h26;
                7'h25:   v = 7'h2A;
                7'h26:   v = 7'h28;
                7'h27:   v = shift ? 7'h29 : 7'h30;
                7'h28:   v = ASCII_LF;
                7'h29:   v = ASCII_ESC;
                7'h2A:   v = ASCII_BS;
                7'h2B:   v = ASCII_TAB;
                7'h2C:   v = 7'h20;
                7'h2D:   v = shift ? 7'h5F : 7'h2D;
                7'h2E:   v = shift ? 7'h2B : 7'h3D;
                7'h2F:   v = shift ? 7'h7B : 7'h5B;
                7'h30:   v = shift ? 7'h7D : 7'h5D;
                7'h31:   v = shift ? 7'h7C : 7'h5C;
                7'h33:   v = shift ? 7'h3A : 7'h3B;
                7'h34:   v = shift ? 7'h22 : 7'h27;
                7'h35:   v = shift ? 7'h7E : 7'h60;
                7'h36:   v = shift ? 7'h3C : 7'h2C;
                7'h37:   v = shift ? 7'h3E : 7'h2E;
                7'h38:   v = shift ? 7'h3F : 7'h2F;
                7'h4C:   v = ASCII_DEL;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/hkbd_cmp.sv @@
// ----------------------------------------------------------------------------
// hkbd_cmp
// Shared compare unit: qualifies one key code and compares it against one
// entry of the previous report.
// ----------------------------------------------------------------------------
`default_nettype none

module hkbd_cmp (
    input  wire logic [7:0]          i_code,
    input  wire logic [7:0]          i_prev,
    output hkbd_pkg::t_cmp_res       o_res
);
    import hkbd_pkg::*;

    always_comb begin
        o_res.code_ok = (i_code != '0) && (i_code < CODE_LIMIT);
        o_res.match   = (i_code == i_prev);
    end

endmodule

`default_nettype wire

@@ sv/hkbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// hkbd_ctrl
// Sequencer: walks the report slots and, for each qualified code, the
// previous-report entries, one compare per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hkbd_ctrl #(
    parameter int unsigned KEY_SLOTS = 6,
    parameter int unsigned IDX_W     = 3
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic                i_enable,
    input  wire logic                i_out_free,
    input  wire hkbd_pkg::t_cmp_res  i_cmp,
    output logic                     o_ready,
    output logic [IDX_W-1:0]         o_slot,
    output logic [IDX_W-1:0]         o_prev,
    output hkbd_pkg::t_cmd           o_cmd
);
    import hkbd_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(KEY_SLOTS - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_slot,  n_slot;
    logic [IDX_W-1:0] r_prev,  n_prev;
    logic             w_last_slot;
    logic             w_last_prev;

    assign w_last_slot = (r_slot == LAST);
    assign w_last_prev = (r_prev == LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
            r_prev  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_prev  <= n_prev;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_prev  = r_prev;
        case (r_state)
            ST_IDLE: begin
                n_slot = '0;
                n_prev = '0;
                if (i_accept) begin
                    n_state = i_enable ? ST_QUAL : ST_FINISH;
                end
            end
            ST_QUAL: begin
                n_prev = '0;
                if (i_cmp.code_ok) begin
                    n_state = ST_CHECK;
                end else if (w_last_slot) begin
                    n_state = ST_FINISH;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_CHECK: begin
                if (i_cmp.match) begin
                    n_prev = '0;
                    if (w_last_slot) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_QUAL;
                        n_slot  = r_slot + 1'b1;
                    end
                end else if (w_last_prev) begin
                    n_state = ST_FINISH;
                end else begin
                    n_prev = r_prev + 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        o_cmd.found  = 1'b0;
        o_cmd.commit = 1'b0;
        o_cmd.store  = 1'b0;
        case (r_state)
            ST_IDLE:  o_ready = 1'b1;
            ST_QUAL:  ;
            ST_CHECK: o_cmd.found = !i_cmp.match && w_last_prev;
            ST_FINISH: begin
                o_cmd.commit = i_out_free;
                o_cmd.store  = i_out_free && i_enable;
            end
            default:  ;
        endcase
    end

    assign o_slot = r_slot;
    assign o_prev = r_prev;

    a_found_at_last_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.found |-> (r_state == ST_CHECK) && w_last_prev && !i_cmp.match)
        else $error("key reported new before all previous entries were checked");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> !o_ready)
        else $error("sequencer still ready after taking a report");

    a_commit_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_ready)
        else $error("sequencer not idle after result commit");

endmodule

`default_nettype wire

@@ sv/hid_boot_keyboard_report_decoder.sv @@
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_decoder
// Decodes HID boot keyboard reports into the ASCII code of the first newly
// pressed key.
//
// Input stream: one transaction per report. tdata carries the modifier byte
// in bits 7:0 and key slots 1..6 in the following bytes. The key codes of the
// last report seen while enabled are kept and compared against.
// Output stream: one transaction per report. tdata[6:0] is the character,
// tuser is the new-press flag.
// Configuration: i_cfg_wr_en writes the enable bit; write only while idle.
// Timing: one compare unit checks one slot against one stored code per
// cycle. For each scanned slot the sequencer qualifies the code, then
// compares it against the stored codes until a match or the last entry;
// a disabled report goes straight to the finish state.
// The input is ready only while the sequencer is idle.
// The result sits in an output register; a new report is taken while it
// waits, and the next result holds in the sequencer until the receiver
// takes the previous one.
// Reset clears the stored codes, the enable bit and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_boot_keyboard_report_decoder #(
    parameter int unsigned KEY_SLOTS = 6
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic                               i_cfg_wr_data,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // modifiers, key_1, key_2, key_3, key_4, key_5, key_6
    input  wire logic [hkbd_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // char_code, one zero pad bit
    output logic [hkbd_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    // new_press
    output logic                                    o_m_axis_tuser
);
    import hkbd_pkg::*;

    localparam int unsigned IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic                                r_enable;
    logic                                r_shift;
    logic [KEY_SLOTS-1:0][CODE_W-1:0]    r_codes;
    logic [KEY_SLOTS-1:0][CODE_W-1:0]    r_prev;
    logic [CHAR_W-1:0]                   r_char;
    logic                                r_hit;
    logic                                r_out_valid;
    logic [CHAR_W-1:0]                   r_out_char;
    logic                                r_out_hit;

    logic                                w_accept;
    logic                                w_out_free;
    logic                                w_ready;
    logic [IDX_W-1:0]                    w_slot;
    logic [IDX_W-1:0]                    w_prev_idx;
    logic [CODE_W-1:0]                   w_code;
    t_cmp_res                            w_cmp;
    t_cmd                                w_cmd;

    assign w_accept   = i_s_axis_tvalid && w_ready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_code     = r_codes[w_slot];

    hkbd_cmp u_cmp (
        .i_code (w_code),
        .i_prev (r_prev[w_prev_idx]),
        .o_res  (w_cmp)
    );

    hkbd_ctrl #(
        .KEY_SLOTS (KEY_SLOTS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_enable   (r_enable),
        .i_out_free (w_out_free),
        .i_cmp      (w_cmp),
        .o_ready    (w_ready),
        .o_slot     (w_slot),
        .o_prev     (w_prev_idx),
        .o_cmd      (w_cmd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (w_cmd.store) begin
                r_prev <= r_codes;
            end
            if (w_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_shift <= (i_s_axis_tdata[CODE_W-1:0] & SHIFT_MASK) != '0;
            for (int s = 0; s < KEY_SLOTS; s++) begin
                r_codes[s] <= i_s_axis_tdata[CODE_W*(s+1) +: CODE_W];
            end
            r_char <= '0;
            r_hit  <= 1'b0;
        end else if (w_cmd.found) begin
            r_char <= f_keymap(w_code[CHAR_W-1:0], r_shift);
            r_hit  <= 1'b1;
        end
        if (w_cmd.commit) begin
            r_out_char <= r_char;
            r_out_hit  <= r_hit;
        end
    end

    assign o_s_axis_tready = w_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_char};
    assign o_m_axis_tuser  = r_out_hit;

    a_no_press_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> (o_m_axis_tdata == '0))
        else $error("character without a new press");

    a_prev_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cmd.store |=> $stable(r_prev))
        else $error("stored codes changed outside a commit");

    a_disabled_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit && !r_enable |-> !r_hit && !w_cmd.store)
        else $error("disabled report produced a press or stored codes");

endmodule

`default_nettype wire
